// File: rtl/pcs_pkg.sv
// Shared constants, types and state encodings of the polyline curvature segmenter.
package pcs_pkg;

	localparam int COORD_W     = 32;
	localparam int SPLIT_LIMIT = 9;
	localparam int MIN_CUT     = 5;
	localparam int RAD_W       = 38;
	localparam int THR_RESET   = 4194304;

	localparam int SEG_W  = $clog2(SPLIT_LIMIT + 2);
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SQ_W   = PROD_W + 1;
	localparam int NUM_W  = DIFF_W + SQ_W + 1;
	localparam int DEN_W  = PROD_W + 2;
	localparam int DV_W   = (NUM_W > DEN_W + RAD_W) ? NUM_W : DEN_W + RAD_W;
	localparam int SUM_W  = 2 * RAD_W + 1;
	localparam int CNT_W  = $clog2(((DIFF_W > RAD_W) ? DIFF_W : RAD_W) + 1);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [RAD_W-1:0] rad_t;

	localparam rad_t RAD_MAX = {RAD_W{1'b1}};

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef enum logic [1:0] {
		JOB_SINGLE,
		JOB_PAIR,
		JOB_TRI
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic      first_tri;
		logic      way_end;
		point_t    older;
		point_t    newer;
		point_t    cur;
	} job_t;

	typedef enum logic [3:0] {
		R_IDLE,
		R_MUL,
		R_SUM,
		R_NUM,
		R_ABS,
		R_DIVI,
		R_DIVS,
		R_SQR,
		R_SQRT,
		R_DONE
	} rad_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RAD,
		B_EMIT0,
		B_EMIT1
	} back_state_t;

endpackage

// File: rtl/pcs_if.sv
// Valid/ready channel interfaces for points in and segmented points out.
interface pcs_in_if;
	logic           valid;
	logic           ready;
	pcs_pkg::coord_t in_x;
	pcs_pkg::coord_t in_y;
	logic           way_end;

	modport source (output valid, output in_x, output in_y, output way_end, input ready);
	modport sink (input valid, input in_x, input in_y, input way_end, output ready);
endinterface

interface pcs_out_if;
	logic           valid;
	logic           ready;
	pcs_pkg::coord_t out_x;
	pcs_pkg::coord_t out_y;
	logic           starts_segment;
	logic           last_of_run;

	modport source (output valid, output out_x, output out_y, output starts_segment,
		output last_of_run, input ready);
	modport sink (input valid, input out_x, input out_y, input starts_segment,
		input last_of_run, output ready);
endinterface

// File: rtl/pcs_fifo.sv
// Two-entry job queue between the front and the back.
module pcs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  pcs_pkg::job_t  push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output pcs_pkg::job_t  pop_data
);
	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	pcs_pkg::job_t mem [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = (cnt_q != (AW+1)'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// File: rtl/pcs_front.sv
// Front: accepts points, keeps history; a way's end or non-first point becomes a job.
module pcs_front (
	input  logic          clk,
	input  logic          arst_n,
	pcs_in_if.sink        in_ch,
	output logic          push_valid,
	input  logic          push_ready,
	output pcs_pkg::job_t job
);
	logic [1:0]       ps_q;
	pcs_pkg::point_t  older_q;
	pcs_pkg::point_t  newer_q;
	pcs_pkg::point_t  cur;
	logic             accept;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && push_ready;
	assign cur.x       = in_ch.in_x;
	assign cur.y       = in_ch.in_y;
	assign push_valid  = accept && !(ps_q == 2'd0 && !in_ch.way_end);

	always_comb begin
		job.kind      = (ps_q == 2'd0) ? pcs_pkg::JOB_SINGLE :
			(ps_q == 2'd1) ? pcs_pkg::JOB_PAIR : pcs_pkg::JOB_TRI;
		job.first_tri = (ps_q == 2'd2);
		job.way_end   = in_ch.way_end;
		job.older     = older_q;
		job.newer     = newer_q;
		job.cur       = cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= '0;
		end else if (accept) begin
			if (in_ch.way_end) begin
				ps_q <= '0;
			end else if (ps_q != 2'd3) begin
				ps_q <= ps_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			older_q <= newer_q;
			newer_q <= cur;
		end
	end
endmodule

// File: rtl/pcs_radius.sv
// Iterative circumradius unit: products, numerators, two divisions and a square root.
module pcs_radius (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pcs_pkg::point_t pa,
	input  pcs_pkg::point_t pb,
	input  pcs_pkg::point_t pc,
	output logic            done,
	output pcs_pkg::rad_t   radius
);
	localparam int DIFF_W = pcs_pkg::DIFF_W;
	localparam int PROD_W = pcs_pkg::PROD_W;
	localparam int NUM_W  = pcs_pkg::NUM_W;
	localparam int DEN_W  = pcs_pkg::DEN_W;
	localparam int DV_W   = pcs_pkg::DV_W;
	localparam int SUM_W  = pcs_pkg::SUM_W;
	localparam int RAD_W  = pcs_pkg::RAD_W;
	localparam int CNT_W  = pcs_pkg::CNT_W;

	pcs_pkg::rad_state_t state_q, state_d;

	logic signed [DIFF_W-1:0] ux_q, uy_q, vx_q, vy_q;
	logic signed [DIFF_W-1:0] dux, duy, dvx, dvy;
	logic                     deg_q;
	logic [CNT_W-1:0]         cnt_q;
	logic signed [PROD_W-1:0] p_q [6];
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [NUM_W-1:0]  uu_q, vv_q, nx_q, ny_q;
	logic signed [NUM_W-1:0]  t_vv, t_uu, t_uu2, t_vv2, nx_next, ny_next;
	logic signed [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]         nmx_q, nmy_q, nsel;
	logic [DEN_W-1:0]         dmag_q;
	logic [DV_W-1:0]          rem_q, dsh_q;
	logic                     sat, ge;
	logic                     sel_q;
	logic [RAD_W-1:0]         qacc_q, qnext, qx_q;
	logic [RAD_W-1:0]         mx_q, my_q;
	logic [SUM_W-1:0]         ax_q, ay_q, sum_q, res_q, one_q, trial, fin;
	logic                     sq_ge;
	logic                     last;
	pcs_pkg::rad_t            rad_q;

	assign dux = DIFF_W'($signed(pb.x)) - DIFF_W'($signed(pa.x));
	assign duy = DIFF_W'($signed(pb.y)) - DIFF_W'($signed(pa.y));
	assign dvx = DIFF_W'($signed(pc.x)) - DIFF_W'($signed(pa.x));
	assign dvy = DIFF_W'($signed(pc.y)) - DIFF_W'($signed(pa.y));

	always_comb begin
		case (cnt_q[2:0])
			3'd5: begin mul_a = ux_q; mul_b = ux_q; end
			3'd4: begin mul_a = uy_q; mul_b = uy_q; end
			3'd3: begin mul_a = vx_q; mul_b = vx_q; end
			3'd2: begin mul_a = vy_q; mul_b = vy_q; end
			3'd1: begin mul_a = vx_q; mul_b = uy_q; end
			default: begin mul_a = ux_q; mul_b = vy_q; end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign last    = (cnt_q == '0);
	assign t_vv    = uy_q[0] ? vv_q : '0;
	assign t_uu    = vy_q[0] ? uu_q : '0;
	assign t_uu2   = vx_q[0] ? uu_q : '0;
	assign t_vv2   = ux_q[0] ? vv_q : '0;
	assign nx_next = last ? nx_q - t_vv + t_uu : nx_q + t_vv - t_uu;
	assign ny_next = last ? ny_q - t_uu2 + t_vv2 : ny_q + t_uu2 - t_vv2;

	assign nsel  = sel_q ? nmy_q : nmx_q;
	assign sat   = DV_W'(nsel) >= (DV_W'(dmag_q) << RAD_W);
	assign ge    = rem_q >= dsh_q;
	assign qnext = {qacc_q[RAD_W-2:0], ge};

	assign trial = res_q | one_q;
	assign sq_ge = sum_q >= trial;
	assign fin   = sq_ge ? ((res_q >> 1) | one_q) : (res_q >> 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcs_pkg::R_IDLE: if (start) state_d = pcs_pkg::R_MUL;
			pcs_pkg::R_MUL:  if (last) state_d = pcs_pkg::R_SUM;
			pcs_pkg::R_SUM: begin
				if (deg_q || p_q[1] == p_q[0]) state_d = pcs_pkg::R_DONE;
				else state_d = pcs_pkg::R_NUM;
			end
			pcs_pkg::R_NUM:  if (last) state_d = pcs_pkg::R_ABS;
			pcs_pkg::R_ABS:  state_d = pcs_pkg::R_DIVI;
			pcs_pkg::R_DIVI: state_d = sat ? pcs_pkg::R_DONE : pcs_pkg::R_DIVS;
			pcs_pkg::R_DIVS: begin
				if (last) state_d = sel_q ? pcs_pkg::R_SQR : pcs_pkg::R_DIVI;
			end
			pcs_pkg::R_SQR:  if (last) state_d = pcs_pkg::R_SQRT;
			pcs_pkg::R_SQRT: if (last) state_d = pcs_pkg::R_DONE;
			pcs_pkg::R_DONE: state_d = pcs_pkg::R_IDLE;
			default: state_d = pcs_pkg::R_IDLE;
		endcase
	end

	always_comb begin
		done   = (state_q == pcs_pkg::R_DONE);
		radius = rad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcs_pkg::R_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pcs_pkg::R_IDLE: begin
				ux_q  <= dux;
				uy_q  <= duy;
				vx_q  <= dvx;
				vy_q  <= dvy;
				deg_q <= (pa.x == pb.x && pa.x == pc.x) || (pa.y == pb.y && pa.y == pc.y);
				cnt_q <= CNT_W'(5);
			end
			pcs_pkg::R_MUL: begin
				p_q[cnt_q[2:0]] <= mul_p;
				cnt_q           <= cnt_q - 1'b1;
			end
			pcs_pkg::R_SUM: begin
				uu_q  <= NUM_W'(p_q[5]) + NUM_W'(p_q[4]);
				vv_q  <= NUM_W'(p_q[3]) + NUM_W'(p_q[2]);
				den_q <= (DEN_W'(p_q[1]) - DEN_W'(p_q[0])) <<< 1;
				nx_q  <= '0;
				ny_q  <= '0;
				rad_q <= '0;
				cnt_q <= CNT_W'(DIFF_W - 1);
			end
			pcs_pkg::R_NUM: begin
				nx_q  <= nx_next;
				ny_q  <= ny_next;
				uu_q  <= uu_q <<< 1;
				vv_q  <= vv_q <<< 1;
				ux_q  <= ux_q >>> 1;
				uy_q  <= uy_q >>> 1;
				vx_q  <= vx_q >>> 1;
				vy_q  <= vy_q >>> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			pcs_pkg::R_ABS: begin
				nmx_q  <= nx_q[NUM_W-1] ? -nx_q : nx_q;
				nmy_q  <= ny_q[NUM_W-1] ? -ny_q : ny_q;
				dmag_q <= den_q[DEN_W-1] ? -den_q : den_q;
				sel_q  <= 1'b0;
			end
			pcs_pkg::R_DIVI: begin
				rem_q  <= DV_W'(nsel);
				dsh_q  <= DV_W'(dmag_q) << (RAD_W - 1);
				qacc_q <= '0;
				rad_q  <= pcs_pkg::RAD_MAX;
				cnt_q  <= CNT_W'(RAD_W - 1);
			end
			pcs_pkg::R_DIVS: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				qacc_q <= qnext;
				dsh_q  <= dsh_q >> 1;
				if (!last) begin
					cnt_q <= cnt_q - 1'b1;
				end else if (!sel_q) begin
					qx_q  <= qnext;
					sel_q <= 1'b1;
				end else begin
					mx_q  <= qx_q;
					ax_q  <= SUM_W'(qx_q);
					my_q  <= qnext;
					ay_q  <= SUM_W'(qnext);
					sum_q <= '0;
					cnt_q <= CNT_W'(RAD_W - 1);
				end
			end
			pcs_pkg::R_SQR: begin
				sum_q <= sum_q + (mx_q[0] ? ax_q : '0) + (my_q[0] ? ay_q : '0);
				ax_q  <= ax_q << 1;
				ay_q  <= ay_q << 1;
				mx_q  <= mx_q >> 1;
				my_q  <= my_q >> 1;
				if (last) begin
					res_q <= '0;
					one_q <= SUM_W'(1) << (SUM_W - 1);
					cnt_q <= CNT_W'(RAD_W);
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			pcs_pkg::R_SQRT: begin
				if (sq_ge) begin
					sum_q <= sum_q - trial;
				end
				res_q <= fin;
				one_q <= one_q >> 2;
				cnt_q <= cnt_q - 1'b1;
				if (last) begin
					rad_q <= (|fin[SUM_W-1:RAD_W]) ? pcs_pkg::RAD_MAX : fin[RAD_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// File: rtl/pcs_back.sv
// Back: runs jobs, smooths radii, decides segment cuts and drives the output register.
module pcs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  pcs_pkg::job_t pop_data,
	input  pcs_pkg::rad_t thr,
	pcs_out_if.source     out_ch
);
	localparam int SEG_W = pcs_pkg::SEG_W;

	pcs_pkg::back_state_t state_q, state_d;
	pcs_pkg::job_t        job_q;
	pcs_pkg::rad_t        r_q, lc_q, last_r_q, last_c_q;
	pcs_pkg::rad_t        lc_c, dcur, dprev, delta;
	logic [SEG_W-1:0]     seg_q, seg_dec;
	logic                 cut;
	logic                 slot_free;
	logic                 emit;
	logic                 rad_start;
	logic                 rad_done;
	pcs_pkg::rad_t        rad_val;
	logic                 out_v_q;
	pcs_pkg::coord_t      ox_q, oy_q;
	logic                 ost_q, olast_q;

	pcs_radius u_radius (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rad_start),
		.pa     (pop_data.older),
		.pb     (pop_data.newer),
		.pc     (pop_data.cur),
		.done   (rad_done),
		.radius (rad_val)
	);

	assign slot_free = !out_v_q || out_ch.ready;
	assign lc_c      = job_q.first_tri ? r_q : ((r_q < last_r_q) ? r_q : last_r_q);
	assign dcur      = (state_q == pcs_pkg::B_EMIT1) ? r_q : lc_c;
	assign dprev     = (state_q == pcs_pkg::B_EMIT1) ? lc_q : last_c_q;
	assign delta     = (dcur > dprev) ? dcur - dprev : dprev - dcur;
	assign cut       = (delta > thr && seg_q >= SEG_W'(pcs_pkg::MIN_CUT)) ||
		seg_q > SEG_W'(pcs_pkg::SPLIT_LIMIT);
	assign seg_dec   = cut ? SEG_W'(1) : seg_q + 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcs_pkg::B_IDLE: begin
				if (pop_valid) begin
					state_d = (pop_data.kind == pcs_pkg::JOB_TRI) ? pcs_pkg::B_RAD :
						pcs_pkg::B_EMIT0;
				end
			end
			pcs_pkg::B_RAD: if (rad_done) state_d = pcs_pkg::B_EMIT0;
			pcs_pkg::B_EMIT0: begin
				if (slot_free) begin
					state_d = (job_q.way_end && job_q.kind != pcs_pkg::JOB_SINGLE) ?
						pcs_pkg::B_EMIT1 : pcs_pkg::B_IDLE;
				end
			end
			pcs_pkg::B_EMIT1: if (slot_free) state_d = pcs_pkg::B_IDLE;
			default: state_d = pcs_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = (state_q == pcs_pkg::B_IDLE);
		rad_start = (state_q == pcs_pkg::B_IDLE) && pop_valid &&
			(pop_data.kind == pcs_pkg::JOB_TRI);
		emit      = (state_q == pcs_pkg::B_EMIT0 || state_q == pcs_pkg::B_EMIT1) && slot_free;
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.out_x          = ox_q;
	assign out_ch.out_y          = oy_q;
	assign out_ch.starts_segment = ost_q;
	assign out_ch.last_of_run    = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pcs_pkg::B_IDLE;
			out_v_q  <= 1'b0;
			seg_q    <= '0;
			last_r_q <= '0;
			last_c_q <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (emit && state_q == pcs_pkg::B_EMIT0) begin
				case (job_q.kind)
					pcs_pkg::JOB_SINGLE: begin
						seg_q    <= '0;
						last_r_q <= '0;
						last_c_q <= '0;
					end
					pcs_pkg::JOB_PAIR: seg_q <= SEG_W'(1);
					pcs_pkg::JOB_TRI: begin
						seg_q <= job_q.first_tri ? SEG_W'(2) : seg_dec;
						if (!job_q.way_end) begin
							last_c_q <= lc_c;
							last_r_q <= r_q;
						end
					end
					default: begin
					end
				endcase
			end else if (emit) begin
				seg_q    <= '0;
				last_r_q <= '0;
				last_c_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			job_q <= pop_data;
		end
		if (state_q == pcs_pkg::B_RAD && rad_done) begin
			r_q <= rad_val;
		end
		if (emit && state_q == pcs_pkg::B_EMIT0) begin
			lc_q    <= lc_c;
			olast_q <= !job_q.way_end || job_q.kind == pcs_pkg::JOB_SINGLE;
			case (job_q.kind)
				pcs_pkg::JOB_SINGLE: begin
					ox_q  <= job_q.cur.x;
					oy_q  <= job_q.cur.y;
					ost_q <= 1'b1;
				end
				pcs_pkg::JOB_PAIR: begin
					ox_q  <= job_q.newer.x;
					oy_q  <= job_q.newer.y;
					ost_q <= 1'b1;
				end
				default: begin
					ox_q  <= job_q.newer.x;
					oy_q  <= job_q.newer.y;
					ost_q <= !job_q.first_tri && cut;
				end
			endcase
		end else if (emit) begin
			ox_q    <= job_q.cur.x;
			oy_q    <= job_q.cur.y;
			ost_q   <= (job_q.kind == pcs_pkg::JOB_TRI) && cut;
			olast_q <= 1'b1;
		end
	end
endmodule

// File: rtl/polyline_curvature_segmenter.sv
// Polyline curvature segmenter top level: threshold register, front, job queue and back.
// Points stream in per way; each point is re-emitted one request behind with a
// new-segment flag, the last point of a way coming out together with the one
// before it. The first two points of a way and a single-point way skip the radius
// unit; every further point runs the iterative circumradius unit (six shared
// 33x33 products, 33 shift-add numerator steps, two divisions, a 38-step square
// sum and a 39-step root; collinear points end early). A two-job queue lets the
// front take the next points while the back computes or waits on the output.
module polyline_curvature_segmenter (
	input  logic                clk,
	input  logic                arst_n,
	pcs_in_if.sink              in_ch,
	pcs_out_if.source           out_ch,
	input  logic                cfg_we,
	input  logic [pcs_pkg::RAD_W-1:0] cfg_wdata
);
	pcs_pkg::rad_t thr_q;
	logic          job_push;
	logic          job_push_rdy;
	pcs_pkg::job_t job_in;
	logic          job_pop_valid;
	logic          job_pop_ready;
	pcs_pkg::job_t job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pcs_pkg::RAD_W'(pcs_pkg::THR_RESET);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	pcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (job_push),
		.push_ready (job_push_rdy),
		.job        (job_in)
	);

	pcs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_push),
		.push_ready (job_push_rdy),
		.push_data  (job_in),
		.pop_valid  (job_pop_valid),
		.pop_ready  (job_pop_ready),
		.pop_data   (job_out)
	);

	pcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (job_pop_valid),
		.pop_ready (job_pop_ready),
		.pop_data  (job_out),
		.thr       (thr_q),
		.out_ch    (out_ch)
	);

`ifndef SYNTH
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> job_push_rdy)
		else $error("job pushed into a full queue");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !out_ch.last_of_run |=> out_ch.valid)
		else $error("second result of a way end not presented");
`endif
endmodule
